>>> rtl/block_cache_clock_replacement_defines.svh
// ----------------------------------------------------------------------------
// Block cache clock replacement: assertion macros
// Shared assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef BLOCK_CACHE_CLOCK_REPLACEMENT_DEFINES_SVH
`define BLOCK_CACHE_CLOCK_REPLACEMENT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCCR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bccr_pkg.sv
// ----------------------------------------------------------------------------
// Block cache clock replacement package
// Transfer types, action and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package bccr_pkg;

  localparam int SLOT_FIELD_W = 6;
  localparam int SECTOR_W     = 32;

  // Action codes carried in the request
  localparam logic [2:0] ACT_READ_GET    = 3'd0;
  localparam logic [2:0] ACT_WRITE_GET   = 3'd1;
  localparam logic [2:0] ACT_RELEASE     = 3'd2;
  localparam logic [2:0] ACT_MARK_DIRTY  = 3'd3;
  localparam logic [2:0] ACT_FLUSH       = 3'd4;
  localparam logic [2:0] ACT_FLUSH_EMPTY = 3'd5;

  // Status codes carried in the response
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_ALL_PINNED = 2'd1;
  localparam logic [1:0] STATUS_NOT_PINNED = 2'd2;
  localparam logic [1:0] STATUS_NOT_IN_USE = 2'd3;

  typedef struct packed {
    logic [2:0]              action;
    logic [SECTOR_W-1:0]     sector;
    logic [SLOT_FIELD_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] slot_used;
    logic                    hit;
    logic                    writeback_valid;
    logic [SECTOR_W-1:0]     writeback_sector;
    logic                    fetch_valid;
    logic [1:0]              status;
    logic                    last;
  } rsp_t;

  // Control strobes from the sequencer to the tag and metadata store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic tag_we;
  } store_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_FILL,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_CLOCK,
    PH_MODIFY,
    PH_FLUSH
  } phase_t;

endpackage

>>> rtl/bccr_store.sv
// ----------------------------------------------------------------------------
// Block cache clock replacement: tag and metadata store
// One tag memory and one metadata memory (pin count, dirty, accessed) that
// share a read address and a write address, with registered read data.
// ----------------------------------------------------------------------------
module bccr_store #(
  parameter int SLOTS = 64,
  parameter int PIN_W = 8
) (
  input  logic                         clk,
  input  bccr_pkg::store_ctl_t         ctl,
  input  logic [$clog2(SLOTS)-1:0]     rd_addr,
  input  logic [$clog2(SLOTS)-1:0]     wr_addr,
  input  logic [bccr_pkg::SECTOR_W-1:0] wr_tag,
  input  logic [PIN_W+1:0]             wr_meta,
  output logic [bccr_pkg::SECTOR_W-1:0] rd_tag,
  output logic [PIN_W+1:0]             rd_meta
);
  import bccr_pkg::*;

  logic [SECTOR_W-1:0] tag_mem  [SLOTS];
  logic [PIN_W+1:0]    meta_mem [SLOTS];

  // Write tag and metadata
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      meta_mem[wr_addr] <= wr_meta;
    end
    if (ctl.tag_we) begin
      tag_mem[wr_addr] <= wr_tag;
    end
  end

  // Read both memories, hold data until the next read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_tag  <= tag_mem[rd_addr];
      rd_meta <= meta_mem[rd_addr];
    end
  end

endmodule

>>> rtl/block_cache_clock_replacement.sv
// ----------------------------------------------------------------------------
// Block cache clock replacement
// Tag and metadata tracker of a sector cache with second-chance eviction.
// ----------------------------------------------------------------------------
// One request at a time. Each slot visit has two steps (read the tag and
// metadata memories, then evaluate and write back), because all slot state
// sits in one single-port-read memory pair. A get searches the slots in use
// from slot 0 for a hit; a miss with a free slot takes the next unused slot,
// and a miss with all slots in use runs a clock scan of up to two passes.
// Release and mark dirty visit only the named slot, if it is in use; a flush
// visits every slot in use and can also wait for the response side. Slots at
// or above the fill count are never read, so the store needs no clearing
// after reset or after flush and empty.
// ----------------------------------------------------------------------------
`include "block_cache_clock_replacement_defines.svh"

module block_cache_clock_replacement #(
  parameter int CACHE_SLOTS = 64,
  parameter int PIN_BITS    = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bccr_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bccr_pkg::rsp_t rsp
);
  import bccr_pkg::*;

  localparam int SLOT_W = $clog2(CACHE_SLOTS);
  localparam int CNT_W  = $clog2(CACHE_SLOTS + 1);
  localparam int META_W = PIN_BITS + 2;
  localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
  localparam logic [SLOT_W-1:0]   IDX_TOP = SLOT_W'(CACHE_SLOTS - 1);
  localparam logic [CNT_W-1:0]    CNT_FULL = CNT_W'(CACHE_SLOTS);

  state_t              state, state_next;
  phase_t              phase, phase_next;
  logic [SLOT_W-1:0]   idx, idx_next;
  logic [CNT_W-1:0]    slots_in_use, slots_in_use_next;
  logic [2:0]          act_q, act_next;
  logic [SECTOR_W-1:0] sector_q, sector_next;
  logic                seen_free, seen_free_next;
  logic                pend_valid, pend_valid_next;
  rsp_t                res, res_next;

  store_ctl_t          ctl;
  logic [SLOT_W-1:0]   wr_addr;
  logic [SECTOR_W-1:0] rd_tag;
  logic [META_W-1:0]   rd_meta, wr_meta;
  logic [PIN_BITS-1:0] rd_pin;
  logic                rd_dirty, rd_acc;
  logic                is_write;
  logic                idx_last_used;
  logic                out_free, out_load;
  rsp_t                out_word;

  bccr_store #(
    .SLOTS (CACHE_SLOTS),
    .PIN_W (PIN_BITS)
  ) u_store (
    .clk     (clk),
    .ctl     (ctl),
    .rd_addr (idx),
    .wr_addr (wr_addr),
    .wr_tag  (sector_q),
    .wr_meta (wr_meta),
    .rd_tag  (rd_tag),
    .rd_meta (rd_meta)
  );

  assign rd_pin        = rd_meta[META_W-1:2];
  assign rd_dirty      = rd_meta[1];
  assign rd_acc        = rd_meta[0];
  assign is_write      = (act_q == ACT_WRITE_GET);
  assign idx_last_used = ((CNT_W'(idx) + CNT_W'(1)) == slots_in_use);
  assign out_free      = !rsp_valid || !rsp_stall;
  assign req_stall     = rst || (state != S_IDLE);

  // Hold the sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_SEARCH;
      slots_in_use <= '0;
      pend_valid   <= 1'b0;
      seen_free    <= 1'b0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      slots_in_use <= slots_in_use_next;
      pend_valid   <= pend_valid_next;
      seen_free    <= seen_free_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    act_q    <= act_next;
    sector_q <= sector_next;
    res      <= res_next;
  end

  // Sequence one request over the slots
  always_comb begin
    state_next        = state;
    phase_next        = phase;
    idx_next          = idx;
    slots_in_use_next = slots_in_use;
    act_next          = act_q;
    sector_next       = sector_q;
    seen_free_next    = seen_free;
    pend_valid_next   = pend_valid;
    res_next          = res;
    ctl               = '0;
    wr_addr           = idx;
    wr_meta           = rd_meta;
    out_load          = 1'b0;
    out_word          = res;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          act_next        = req.action;
          sector_next     = req.sector;
          res_next        = '0;
          pend_valid_next = 1'b0;
          seen_free_next  = 1'b0;
          idx_next        = '0;
          case (req.action)
            ACT_READ_GET, ACT_WRITE_GET: begin
              phase_next = PH_SEARCH;
              state_next = (slots_in_use == '0) ? S_FILL : S_RD;
            end
            ACT_RELEASE, ACT_MARK_DIRTY: begin
              phase_next = PH_MODIFY;
              if (32'(req.slot) >= 32'(slots_in_use)) begin
                res_next.status = STATUS_NOT_IN_USE;
                state_next      = S_DONE;
              end else begin
                idx_next   = SLOT_W'(req.slot);
                state_next = S_RD;
              end
            end
            ACT_FLUSH, ACT_FLUSH_EMPTY: begin
              phase_next = PH_FLUSH;
              state_next = (slots_in_use == '0) ? S_DONE : S_RD;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = S_EV;
      end

      S_EV: begin
        case (phase)
          PH_SEARCH: begin
            if (rd_tag == sector_q) begin
              // Hit: pin, mark accessed, and dirty for a write
              ctl.wr_en = 1'b1;
              wr_meta   = {(rd_pin == PIN_MAX) ? rd_pin : rd_pin + PIN_BITS'(1),
                           rd_dirty | is_write, 1'b1};
              res_next.slot_used = SLOT_FIELD_W'(idx);
              res_next.hit       = 1'b1;
              state_next         = S_DONE;
            end else if (idx_last_used) begin
              if (slots_in_use != CNT_FULL) begin
                state_next = S_FILL;
              end else begin
                phase_next = PH_CLOCK;
                idx_next   = '0;
                state_next = S_RD;
              end
            end else begin
              idx_next   = idx + SLOT_W'(1);
              state_next = S_RD;
            end
          end

          PH_CLOCK: begin
            state_next = S_RD;
            if (rd_pin == '0 && !rd_acc) begin
              // Victim: report old dirty contents, refill
              ctl.wr_en  = 1'b1;
              ctl.tag_we = 1'b1;
              wr_meta    = {PIN_BITS'(1), is_write, 1'b1};
              res_next.slot_used        = SLOT_FIELD_W'(idx);
              res_next.writeback_valid  = rd_dirty;
              res_next.writeback_sector = rd_dirty ? rd_tag : '0;
              res_next.fetch_valid      = 1'b1;
              state_next                = S_DONE;
            end else begin
              if (rd_pin == '0) begin
                // Second chance: drop the accessed bit
                ctl.wr_en      = 1'b1;
                wr_meta        = {rd_pin, rd_dirty, 1'b0};
                seen_free_next = 1'b1;
              end
              if (idx == IDX_TOP) begin
                idx_next = '0;
                if (!seen_free_next) begin
                  res_next.status = STATUS_ALL_PINNED;
                  state_next      = S_DONE;
                end
              end else begin
                idx_next = idx + SLOT_W'(1);
              end
            end
          end

          PH_MODIFY: begin
            state_next = S_DONE;
            if (act_q == ACT_RELEASE) begin
              if (rd_pin == '0) begin
                res_next.status = STATUS_NOT_PINNED;
              end else begin
                ctl.wr_en = 1'b1;
                wr_meta   = {rd_pin - PIN_BITS'(1), rd_dirty, rd_acc};
              end
            end else begin
              ctl.wr_en = 1'b1;
              wr_meta   = {rd_pin, 1'b1, rd_acc};
            end
          end

          default: begin
            // Flush: hold back each dirty slot until the next one is known
            if (!(rd_dirty && pend_valid && !out_free)) begin
              ctl.wr_en = 1'b1;
              wr_meta   = {rd_pin, 1'b0, 1'b0};
              if (rd_dirty) begin
                if (pend_valid) begin
                  out_load      = 1'b1;
                  out_word      = res;
                  out_word.last = 1'b0;
                end
                res_next                  = '0;
                res_next.slot_used        = SLOT_FIELD_W'(idx);
                res_next.writeback_valid  = 1'b1;
                res_next.writeback_sector = rd_tag;
                pend_valid_next           = 1'b1;
              end
              if (idx_last_used) begin
                state_next = S_DONE;
              end else begin
                idx_next   = idx + SLOT_W'(1);
                state_next = S_RD;
              end
            end
          end
        endcase
      end

      S_FILL: begin
        // Take the next unused slot
        wr_addr           = SLOT_W'(slots_in_use);
        ctl.wr_en         = 1'b1;
        ctl.tag_we        = 1'b1;
        wr_meta           = {PIN_BITS'(1), is_write, 1'b1};
        slots_in_use_next = slots_in_use + CNT_W'(1);
        res_next.slot_used   = SLOT_FIELD_W'(slots_in_use);
        res_next.fetch_valid = 1'b1;
        state_next           = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_word      = res;
          out_word.last = 1'b1;
          if (act_q == ACT_FLUSH_EMPTY) begin
            slots_in_use_next = '0;
          end
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold the response register until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp <= out_word;
    end
  end

  `BCCR_ASSERT_SAME(a_fill_bound, 1'b1, slots_in_use <= CNT_FULL, "fill count past slot count")
  `BCCR_ASSERT_SAME(a_mid_only_flush, rsp_valid && !rsp.last, (act_q == ACT_FLUSH) || (act_q == ACT_FLUSH_EMPTY), "non-final response outside flush")
  `BCCR_ASSERT_SAME(a_hit_no_move, rsp_valid && rsp.hit, !rsp.fetch_valid && !rsp.writeback_valid, "hit with disk request")
  `BCCR_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state != S_IDLE, "request accepted but sequencer idle")

endmodule
